// ----- sv/hksa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the heatmap kernel splat accumulator.
// No dependencies; every other file of the block imports this package.
package hksa_pkg;

    // default sizes of the grid store and the kernel radius limit
    localparam int GRID_CELLS_DEF = 65536;
    localparam int MAX_RADIUS_DEF = 64;

    // field widths
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 12;
    localparam int WEIGHT_W   = 32;
    localparam int INDEX_W    = 16;
    localparam int LEVEL_W    = 17;
    localparam int PEAK_W     = 39;
    localparam int SUM_W      = 40;
    localparam int DIM_W      = 11;
    localparam int RAD_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 39;

    // internal widths: window geometry, cell address, quotient
    localparam int GEOM_W = 14;
    localparam int IDX_W  = 23;
    localparam int QUO_W  = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SPLAT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_CELLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT_MAX = 2'd3;

    // full-scale level, 1.0 in Q1.16
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

    // saturation bounds of a cell sum
    localparam logic [SUM_W-1:0] SUM_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 40'h80_0000_0000;

endpackage

// ----- sv/heatmap_kernel_splat_accumulator_core.sv -----
`timescale 1ns / 1ps
// Heatmap accumulator top level: command sequencer, cell RAM and shared divider.
// Depends on hksa_pkg, hksa_ram and hksa_div.
//
// The block keeps a grid of Q24.16 density sums in one synchronous RAM plus a
// running peak, and takes one command word at a time. A clear sweeps the RAM
// writing zeros, one cell per cycle; the same sweep runs after reset, and no
// word is accepted until it ends. A splat walks its clipped window row by row,
// one cell at a time: each cell in the kernel goes through address, read,
// square, multiply, a 32-step bit-serial divide and a write-back, while a
// skipped cell goes from the check straight to the next cell. A read looks up
// its cell and uses the divider only when the level needs it. The result word
// sits in an output register, so the next command word is taken while it
// waits. Only one cell is in flight, so RAM read and write-back of the same
// cell never overlap.
module heatmap_kernel_splat_accumulator_core
    import hksa_pkg::*;
#(
    parameter int GRID_CELLS = GRID_CELLS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wen,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // command words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_command,
    input  logic signed [COORD_W-1:0]   s_point_x,
    input  logic signed [COORD_W-1:0]   s_point_y,
    input  logic signed [WEIGHT_W-1:0]  s_weight,
    input  logic [INDEX_W-1:0]          s_cell_index,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [LEVEL_W-1:0]          m_level,
    output logic [PEAK_W-1:0]           m_peak
);

    localparam int AW   = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int R2W  = 2 * RW;
    localparam int D2W  = 2 * RW + 1;
    localparam int NUMW = 4 * RW;
    localparam int DSW  = (NUMW > SUM_W) ? NUMW : SUM_W;
    localparam int DDW  = DSW + QUO_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_WIN  = 4'd2;
    localparam logic [3:0] ST_DEN  = 4'd3;
    localparam logic [3:0] ST_ADDR = 4'd4;
    localparam logic [3:0] ST_CHK  = 4'd5;
    localparam logic [3:0] ST_SQ   = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_SDIV = 4'd8;
    localparam logic [3:0] ST_DWT  = 4'd9;
    localparam logic [3:0] ST_UPD  = 4'd10;
    localparam logic [3:0] ST_NEXT = 4'd11;
    localparam logic [3:0] ST_RCHK = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    // configuration registers
    logic [DIM_W-1:0]      grid_w_reg;
    logic [DIM_W-1:0]      grid_h_reg;
    logic [RAD_W-1:0]      radius_reg;
    logic [PEAK_W-1:0]     emax_reg;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  clr_out_reg, clr_out_next;
    logic [SUM_W-1:0]      peak_reg, peak_next;
    logic                  m_valid_reg, m_valid_next;

    // working registers
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [WEIGHT_W-1:0] w_reg, w_next;
    logic [RW-1:0]             r_reg, r_next;
    logic [R2W-1:0]            r2_reg, r2_next;
    logic [NUMW-1:0]           den_reg, den_next;
    logic signed [GEOM_W-1:0]  x0_reg, x0_next, x1_reg, x1_next;
    logic signed [GEOM_W-1:0]  y0_reg, y0_next, y1_reg, y1_next;
    logic [DIM_W-1:0]          x_reg, x_next, y_reg, y_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [D2W-1:0]            d2_reg, d2_next;
    logic [R2W-1:0]            t_reg, t_next;
    logic [NUMW-1:0]           num_reg, num_next;
    logic [SUM_W-1:0]          cell_reg, cell_next;
    logic [DDW-1:0]            dd_reg, dd_next;
    logic [DSW-1:0]            ds_reg, ds_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;
    logic [LEVEL_W-1:0]        m_level_reg, m_level_next;
    logic [PEAK_W-1:0]         m_peak_reg, m_peak_next;

    // RAM and divider hookup
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [SUM_W-1:0]      ram_wr_data;
    logic [SUM_W-1:0]      ram_rd_data;
    logic                  div_done;
    logic [QUO_W-1:0]      div_quo;

    // combinational helpers
    logic                      accept;
    logic [8:0]                r_wide;
    logic signed [GEOM_W-1:0]  px_s, py_s, r_s, w_s, h_s;
    logic signed [GEOM_W-1:0]  lo_x, hi_x, lo_y, hi_y;
    logic signed [GEOM_W-1:0]  dx, dy, adx_f, ady_f;
    logic [RW-1:0]             adx, ady;
    logic                      skip;
    logic [WEIGHT_W-1:0]       w_mag;
    logic signed [SUM_W:0]     score, sum;
    logic [SUM_W-1:0]          nv;
    logic [PEAK_W-1:0]         scale;
    logic signed [GEOM_W-1:0]  x_inc, y_inc;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_peak  = m_peak_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= 11'd256;
            grid_h_reg <= 11'd256;
            radius_reg <= 7'd10;
            emax_reg   <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_GRID_WIDTH:   grid_w_reg <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT:  grid_h_reg <= cfg_data[DIM_W-1:0];
                REG_RADIUS_CELLS: radius_reg <= cfg_data[RAD_W-1:0];
                REG_EXPLICIT_MAX: emax_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        // radius clamped to the kernel limit
        r_wide = ({2'b00, radius_reg} > 9'(MAX_RADIUS)) ? 9'(MAX_RADIUS)
                                                          : {2'b00, radius_reg};
        // window bounds
        px_s  = GEOM_W'(px_reg);
        py_s  = GEOM_W'(py_reg);
        r_s   = $signed({{(GEOM_W-RW){1'b0}}, r_reg});
        w_s   = $signed({3'b000, grid_w_reg});
        h_s   = $signed({3'b000, grid_h_reg});
        lo_x  = px_s - r_s;
        hi_x  = px_s + r_s;
        lo_y  = py_s - r_s;
        hi_y  = py_s + r_s;
        // distance to the point, always within the radius inside the window
        dx    = px_s - $signed({3'b000, x_reg});
        dy    = py_s - $signed({3'b000, y_reg});
        adx_f = dx[GEOM_W-1] ? -dx : dx;
        ady_f = dy[GEOM_W-1] ? -dy : dy;
        adx   = adx_f[RW-1:0];
        ady   = ady_f[RW-1:0];
        skip  = (idx_reg >= IDX_W'(GRID_CELLS)) || (d2_reg > D2W'(r2_reg));
        // weighted kernel and saturating accumulate
        w_mag = w_reg[WEIGHT_W-1] ? WEIGHT_W'(-w_reg) : WEIGHT_W'(w_reg);
        score = w_reg[WEIGHT_W-1] ? -$signed({9'd0, div_quo})
                                  : $signed({9'd0, div_quo});
        sum   = $signed({cell_reg[SUM_W-1], cell_reg}) + score;
        if (sum[SUM_W] != sum[SUM_W-1]) begin
            nv = sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            nv = sum[SUM_W-1:0];
        end
        scale = (emax_reg != '0) ? emax_reg : peak_reg[PEAK_W-1:0];
        x_inc = $signed({3'b000, x_reg}) + GEOM_W'(1);
        y_inc = $signed({3'b000, y_reg}) + GEOM_W'(1);

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_out_next = clr_out_reg;
        peak_next    = peak_reg;
        cmd_next     = cmd_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        w_next       = w_reg;
        r_next       = r_reg;
        r2_next      = r2_reg;
        den_next     = den_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        y0_next      = y0_reg;
        y1_next      = y1_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        idx_next     = idx_reg;
        d2_next      = d2_reg;
        t_next       = t_reg;
        num_next     = num_reg;
        cell_next    = cell_reg;
        dd_next      = dd_reg;
        ds_next      = ds_reg;
        level_next   = level_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = idx_reg[AW-1:0];
        ram_wr_en    = 1'b0;
        ram_wr_addr  = idx_reg[AW-1:0];
        ram_wr_data  = nv;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next   = s_command;
                    px_next    = s_point_x;
                    py_next    = s_point_y;
                    w_next     = s_weight;
                    r_next     = RW'(r_wide);
                    level_next = '0;
                    case (s_command)
                        CMD_CLEAR: begin
                            clr_cnt_next = '0;
                            clr_out_next = 1'b1;
                            peak_next    = '0;
                            state_next   = ST_CLR;
                        end
                        CMD_SPLAT: state_next = ST_WIN;
                        CMD_READ: begin
                            if ({5'd0, s_cell_index} >= 21'(GRID_CELLS)) begin
                                state_next = ST_DONE;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(s_cell_index);
                                state_next  = ST_RCHK;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(GRID_CELLS - 1)) begin
                    state_next = clr_out_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_WIN: begin
                x0_next = lo_x[GEOM_W-1] ? '0 : lo_x;
                x1_next = (hi_x < w_s) ? hi_x : w_s;
                y0_next = lo_y[GEOM_W-1] ? '0 : lo_y;
                y1_next = (hi_y < h_s) ? hi_y : h_s;
                r2_next = R2W'(r_reg * r_reg);
                state_next = ST_DEN;
            end
            ST_DEN: begin
                den_next = NUMW'(r2_reg * r2_reg);
                x_next   = x0_reg[DIM_W-1:0];
                y_next   = y0_reg[DIM_W-1:0];
                if (r_reg == '0 || x0_reg >= x1_reg || y0_reg >= y1_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                idx_next = IDX_W'(y_reg) * IDX_W'(grid_w_reg) + IDX_W'(x_reg);
                d2_next  = D2W'(adx * adx) + D2W'(ady * ady);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                t_next = R2W'(D2W'(r2_reg) - d2_reg);
                if (skip) begin
                    state_next = ST_NEXT;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                num_next   = NUMW'(t_reg * t_reg);
                cell_next  = ram_rd_data;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // round to nearest: add half the divisor before dividing
                dd_next = DDW'(w_mag) * DDW'(num_reg) + DDW'(den_reg >> 1);
                ds_next = DSW'(den_reg);
                state_next = ST_SDIV;
            end
            ST_SDIV: state_next = ST_DWT;
            ST_DWT: begin
                if (div_done) begin
                    if (cmd_reg == CMD_READ) begin
                        level_next = (div_quo > QUO_W'(LEVEL_ONE)) ? LEVEL_ONE
                                                                   : div_quo[LEVEL_W-1:0];
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                ram_wr_en = 1'b1;
                if ($signed(nv) > $signed(peak_reg)) begin
                    peak_next = nv;
                end
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (x_inc < x1_reg) begin
                    x_next     = x_reg + DIM_W'(1);
                    state_next = ST_ADDR;
                end else begin
                    x_next = x0_reg[DIM_W-1:0];
                    if (y_inc < y1_reg) begin
                        y_next     = y_reg + DIM_W'(1);
                        state_next = ST_ADDR;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RCHK: begin
                cell_next = ram_rd_data;
                if (ram_rd_data[SUM_W-1] || ram_rd_data == '0) begin
                    level_next = '0;
                    state_next = ST_DONE;
                end else if (scale == '0) begin
                    level_next = LEVEL_ONE;
                    state_next = ST_DONE;
                end else if (ram_rd_data >= {scale, 1'b0}) begin
                    // quotient at least two: clamps to full level
                    level_next = LEVEL_ONE;
                    state_next = ST_DONE;
                end else begin
                    dd_next    = DDW'({ram_rd_data[PEAK_W-1:0], 16'h0000});
                    ds_next    = DSW'(scale);
                    state_next = ST_SDIV;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_level_next = m_level_reg;
        m_peak_next  = m_peak_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_level_next = level_reg;
            m_peak_next  = peak_reg[PEAK_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            clr_out_reg <= 1'b0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_out_reg <= clr_out_next;
            peak_reg    <= peak_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        w_reg       <= w_next;
        r_reg       <= r_next;
        r2_reg      <= r2_next;
        den_reg     <= den_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        idx_reg     <= idx_next;
        d2_reg      <= d2_next;
        t_reg       <= t_next;
        num_reg     <= num_next;
        cell_reg    <= cell_next;
        dd_reg      <= dd_next;
        ds_reg      <= ds_next;
        level_reg   <= level_next;
        m_level_reg <= m_level_next;
        m_peak_reg  <= m_peak_next;
    end

    // cell sum store
    hksa_ram #(
        .DEPTH (GRID_CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    // shared divider: kernel normalization and read level
    hksa_div #(
        .DSW (DSW),
        .DDW (DDW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_SDIV),
        .dividend (dd_reg),
        .divisor  (ds_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule

// ----- sv/hksa_ram.sv -----
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM holding the cell sums.
// Uses hksa_pkg for the word width. Read data is registered.
module hksa_ram
    import hksa_pkg::*;
#(
    parameter int DEPTH = GRID_CELLS_DEF,
    parameter int AW    = 16
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [SUM_W-1:0] wr_data,
    output logic [SUM_W-1:0] rd_data
);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its word when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/hksa_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Uses hksa_pkg. Caller guarantees the quotient fits in QUO_W bits.
module hksa_div
    import hksa_pkg::*;
#(
    parameter int DSW = 40,
    parameter int DDW = DSW + QUO_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DDW-1:0]   dividend,
    input  logic [DSW-1:0]   divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSW-1:0]   rem_reg, rem_next;
    logic [DSW-1:0]   dsr_reg, dsr_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DSW:0]     shifted;
    logic [DSW:0]     diff;

    // one long-division step: shift in the next dividend bit, try subtract
    always_comb begin
        shifted   = {rem_reg, low_reg[QUO_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = dividend[DDW-1:QUO_W];
            low_next  = dividend[QUO_W-1:0];
            dsr_next  = divisor;
        end else if (busy_reg) begin
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            if (!diff[DSW]) begin
                rem_next = diff[DSW-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DSW-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- verif/tb_heatmap_kernel_splat_accumulator_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the heatmap accumulator: directed and random command words.
// Depends on hksa_pkg and heatmap_kernel_splat_accumulator_core.
module tb_heatmap_kernel_splat_accumulator_core;
    import hksa_pkg::*;

    localparam int  NCELLS      = GRID_CELLS_DEF;
    localparam int  RAD_LIMIT   = MAX_RADIUS_DEF;
    localparam longint SAT_HI   = 64'sd549755813887;
    localparam longint SAT_LO   = -64'sd549755813888;
    localparam longint CYCLE_CAP = 6000000;
    // command code with no function: the block only reports the peak
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]           command;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [WEIGHT_W-1:0] weight;
        logic [INDEX_W-1:0]         index;
    } cmd_word_t;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [PEAK_W-1:0]  peak;
    } heat_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wen;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command;
    logic signed [COORD_W-1:0]  s_point_x;
    logic signed [COORD_W-1:0]  s_point_y;
    logic signed [WEIGHT_W-1:0] s_weight;
    logic [INDEX_W-1:0]         s_cell_index;
    logic                       m_valid;
    logic                       m_ready;
    logic [LEVEL_W-1:0]         m_level;
    logic [PEAK_W-1:0]          m_peak;

    heatmap_kernel_splat_accumulator_core DUT (.*);

    // shadow grid, peak and register copies
    longint       grid_sums [NCELLS];
    longint       grid_peak;
    int           cols, rows, radius;
    longint       fixed_max;

    cmd_word_t    word_queue [$];
    heat_result_t expected_results [$];
    int           send_idle, recv_idle;
    bit           word_taken;
    int           errors;
    longint       cycles;
    int           words_sent, reads_sent, splats_sent, clears_sent;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // quartic splat into the shadow grid
    task automatic splat_grid(int px, int py, longint w);
        int r, x0, x1, y0, y1;
        longint r2, den, idx, d2, t, num, mag, q, nv;
        r  = radius > RAD_LIMIT ? RAD_LIMIT : radius;
        x0 = px - r < 0 ? 0 : px - r;
        x1 = px + r < cols ? px + r : cols;
        y0 = py - r < 0 ? 0 : py - r;
        y1 = py + r < rows ? py + r : rows;
        r2  = longint'(r) * r;
        den = r2 * r2;
        if (r == 0) return;
        mag = w < 0 ? -w : w;
        for (int x = x0; x < x1; x++) begin
            for (int y = y0; y < y1; y++) begin
                idx = longint'(y) * cols + x;
                d2  = longint'(px - x) * (px - x) + longint'(py - y) * (py - y);
                if (idx >= NCELLS || d2 > r2) continue;
                t   = r2 - d2;
                num = t * t;
                q   = (mag * num + den / 2) / den;
                nv  = grid_sums[idx] + (w < 0 ? -q : q);
                if (nv > SAT_HI) nv = SAT_HI;
                if (nv < SAT_LO) nv = SAT_LO;
                if (nv > grid_peak) grid_peak = nv;
                grid_sums[idx] = nv;
            end
        end
    endtask

    // normalized Q1.16 level of one cell
    function automatic logic [LEVEL_W-1:0] cell_level(int idx);
        longint c, scale, q;
        if (idx >= NCELLS) return '0;
        c = grid_sums[idx];
        if (c <= 0) return '0;
        scale = fixed_max != 0 ? fixed_max : grid_peak;
        if (scale == 0) return LEVEL_ONE;
        q = (c <<< 16) / scale;
        return q > 65536 ? LEVEL_ONE : LEVEL_W'(q);
    endfunction

    // input side: one new word per handshake, random gaps
    always @(negedge aclk) begin
        cmd_word_t cw;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || word_taken) begin
                word_taken = 1'b0;
                if (word_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cw = word_queue.pop_front();
                    s_valid      <= 1'b1;
                    s_command    <= cw.command;
                    s_point_x    <= cw.px;
                    s_point_y    <= cw.py;
                    s_weight     <= cw.weight;
                    s_cell_index <= cw.index;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // prediction on accept, check on result, watchdog
    always @(posedge aclk) begin
        heat_result_t exp_r;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("heatmap_kernel_splat_accumulator_core verification failed");
            $finish;
        end else begin
            if (aresetn && s_valid && s_ready) begin
                exp_r.level = '0;
                case (s_command)
                    CMD_CLEAR: begin
                        foreach (grid_sums[i]) grid_sums[i] = 0;
                        grid_peak = 0;
                    end
                    CMD_SPLAT: splat_grid(int'(s_point_x), int'(s_point_y),
                                          longint'(s_weight));
                    CMD_READ:  exp_r.level = cell_level(int'(s_cell_index));
                    default: ;
                endcase
                exp_r.peak = PEAK_W'(grid_peak);
                expected_results.push_back(exp_r);
                word_taken = 1'b1;
            end
            if (aresetn && m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word level=%0d peak=%0d",
                             $time, m_level, m_peak);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_level !== exp_r.level) begin
                        $display("%0t: level expected %0d actual %0d",
                                 $time, exp_r.level, m_level);
                        errors++;
                    end
                    if (m_peak !== exp_r.peak) begin
                        $display("%0t: peak expected %0d actual %0d",
                                 $time, exp_r.peak, m_peak);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:   cols      = int'(value & 'h7FF);
            REG_GRID_HEIGHT:  rows      = int'(value & 'h7FF);
            REG_RADIUS_CELLS: radius    = int'(value & 'h7F);
            REG_EXPLICIT_MAX: fixed_max = value & 'h7F_FFFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic setup(int w, int h, int r, longint m);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_RADIUS_CELLS, r);
        write_reg(REG_EXPLICIT_MAX, m);
    endtask

    // wait until every queued word went in and every result came back
    task automatic drain();
        do @(posedge aclk);
        while (word_queue.size() > 0 || s_valid || expected_results.size() > 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic push(logic [CMD_W-1:0] c, int px, int py, longint w, int idx);
        cmd_word_t cw;
        cw.command = c;
        cw.px      = COORD_W'(px);
        cw.py      = COORD_W'(py);
        cw.weight  = WEIGHT_W'(w);
        cw.index   = INDEX_W'(idx);
        word_queue.push_back(cw);
        words_sent++;
        if (c == CMD_READ)  reads_sent++;
        if (c == CMD_SPLAT) splats_sent++;
        if (c == CMD_CLEAR) clears_sent++;
    endtask

    // random word aimed at the current grid; clears only when allowed
    task automatic push_random(bit allow_clear);
        int sel, px, py, idx, span;
        longint w;
        sel  = $urandom_range(99);
        span = radius > RAD_LIMIT ? RAD_LIMIT : radius;
        if ($urandom_range(9) == 0) begin
            px = $signed(12'($urandom));
            py = $signed(12'($urandom));
        end else begin
            px = $urandom_range(cols + 2 * span + 2) - span - 2;
            py = $urandom_range(rows + 2 * span + 2) - span - 2;
        end
        case ($urandom_range(3))
            0:       w = longint'($signed(32'($urandom)));
            1:       w = -longint'($urandom_range(1 << 20));
            default: w = $urandom_range(1 << 20);
        endcase
        idx = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                       : $urandom_range(cols * rows - 1);
        if (allow_clear && sel == 0)
            push(CMD_CLEAR, px, py, w, idx);
        else if (sel < 3)
            push(CMD_UNUSED, px, py, w, idx);
        else if (sel < 55)
            push(CMD_SPLAT, px, py, w, idx);
        else
            push(CMD_READ, px, py, w, idx);
    endtask

    initial begin
        int clears_left;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        m_ready   = 1'b0;
        s_command = '0;
        s_point_x = '0;
        s_point_y = '0;
        s_weight  = '0;
        s_cell_index = '0;
        word_taken = 1'b0;
        errors = 0;
        cycles = 0;
        foreach (grid_sums[i]) grid_sums[i] = 0;
        grid_peak = 0;
        cols = 256; rows = 256; radius = 10; fixed_max = 0;
        send_idle = 38;
        recv_idle = 38;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset config, corners, extremes of weight, unused command
        push(CMD_READ, 0, 0, 0, 0);
        push(CMD_SPLAT, 5, 5, 65536, 0);
        push(CMD_READ, 0, 0, 0, 5 * 256 + 5);
        push(CMD_READ, 0, 0, 0, 65535);
        push(CMD_UNUSED, 0, 0, 0, 0);
        push(CMD_SPLAT, -2048, -2048, 32'h7FFF_FFFF, 0);
        push(CMD_SPLAT, 2047, 2047, 32'h7FFF_FFFF, 0);
        push(CMD_SPLAT, 5, 5, -64'sd2147483648, 0);
        push(CMD_READ, 0, 0, 0, 5 * 256 + 5);
        push(CMD_CLEAR, 0, 0, 0, 0);
        drain();

        // widest grid: rows past the store are skipped
        setup(1024, 1024, 3, 0);
        push(CMD_SPLAT, 10, 70, 65536, 0);
        push(CMD_SPLAT, 1020, 63, 65536, 0);
        push(CMD_READ, 0, 0, 0, 63 * 1024 + 1020);
        push(CMD_READ, 0, 0, 0, 62 * 1024 + 1021);
        drain();

        // radius above the limit, explicit max at both ends
        setup(2, 2, 127, 1);
        push(CMD_SPLAT, 0, 0, 32'h0123_4567, 0);
        push(CMD_READ, 0, 0, 0, 3);
        drain();
        setup(1, 1, 64, 64'h7F_FFFF_FFFF);
        push(CMD_SPLAT, 0, 0, 32'h7FFF_FFFF, 0);
        push(CMD_READ, 0, 0, 0, 0);
        drain();
        // zero radius and zero width leave the grid alone
        setup(0, 1, 0, 0);
        push(CMD_SPLAT, 0, 0, 65536, 0);
        drain();
        setup(0, 4, 2, 0);
        push(CMD_SPLAT, 0, 0, 65536, 0);
        push(CMD_READ, 0, 0, 0, 0);
        drain();

        // small grid, mixed commands, random idling on both sides
        clears_left = 1;
        setup(16, 16, $urandom_range(1, 4), 0);
        for (int i = 0; i < 100; i++) begin
            push_random(clears_left > 0);
            if (clears_sent > 2) clears_left = 0;
            if (i == 50) drain();
        end
        drain();

        // no idling on either side, explicit max random
        send_idle = 0;
        recv_idle = 0;
        setup(40, 3, $urandom_range(1, 3), {$urandom, $urandom} & 'h7F_FFFF_FFFF);
        for (int i = 0; i < 80; i++) push_random(1'b0);
        drain();
        send_idle = 38;
        recv_idle = 38;

        // one cell hammered with full weight until the sum saturates
        setup(1, 1, 1, 0);
        for (int i = 0; i < 270; i++) begin
            if (i % 30 == 29) push(CMD_READ, 0, 0, 0, 0);
            else push(CMD_SPLAT, 0, 0, 32'h7FFF_FFFF, 0);
        end
        push(CMD_SPLAT, 0, 0, -64'sd2147483648, 0);
        push(CMD_READ, 0, 0, 0, 0);
        drain();

        // random geometry
        setup($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 5),
              $urandom_range(1) ? 0 : longint'($urandom));
        for (int i = 0; i < 100; i++) push_random(clears_sent < 4);
        drain();

        $display("%0d words: %0d splats, %0d reads, %0d clears over grids up to 1024 wide",
                 words_sent, splats_sent, reads_sent, clears_sent);
        $display("covered radius clamp, store overflow, saturation and both scales");
        if (errors == 0) begin
            $display("heatmap_kernel_splat_accumulator_core verification clean");
        end else begin
            $display("heatmap_kernel_splat_accumulator_core verification failed");
        end
        $finish;
    end

endmodule
